// ===== rtl/sitrt_pkg.sv =====
// Shared constants, register index codes, controller state and command/status
// types for the signed integer to radix text core.
// No dependencies.
package sitrt_pkg;

	localparam int VALUE_W     = 32;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = 6;
	localparam int WORD_W      = 64;
	localparam int WORD_COUNT  = 6;
	localparam int MAX_SYMBOLS = 48;
	localparam int DIGIT_DEPTH = 32;
	localparam int DIGIT_W     = 6;
	localparam int PTR_W       = $clog2(DIGIT_DEPTH);
	localparam int LEN_W       = PTR_W + 1;
	localparam int BIT_CNT_W   = $clog2(VALUE_W);
	localparam int CFG_IDX_W   = $clog2(WORD_COUNT + 1);
	localparam int WSEL_W      = CNT_W - 3;
	localparam int CHAR_SPACE  = 1 << SYM_W;

	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CHAR_LOW   = 8'd32;
	localparam logic [SYM_W-1:0] CHAR_HIGH  = 8'd126;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_WORD0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_WORD5 = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	typedef struct packed {
		logic start;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic neg;
		logic out_free;
		logic digit_last;
	} conv_status_t;

	typedef struct packed {
		logic chk_done;
		logic chk_ok;
	} chk_status_t;

endpackage

// ===== rtl/sitrt_value_if.sv =====
// Input channel carrying one signed value per transfer.
// Depends on sitrt_pkg.
interface sitrt_value_if
	import sitrt_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/sitrt_char_if.sv =====
// Output channel carrying one character and its end marker per transfer.
// Depends on sitrt_pkg.
interface sitrt_char_if
	import sitrt_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/signed_integer_to_radix_text_core.sv =====
// Top level of the signed integer to radix text core: controller, alphabet
// unit and conversion datapath. Depends on sitrt_pkg, sitrt_value_if, sitrt_char_if.
//
//  channel   direction  payload                  per transfer
//  number    in         value (32 bit, signed)   one integer
//  text      out        symbol (8 bit), last     one character
//  cfg_*     in         index (3 bit), 64 bit    one register write
//
// an integer is accepted, then converted bit-serially beside the alphabet check; once both
// are done, sign or digits are chosen, then one character per cycle, while text does not
// stall, goes into the output register
// reset clears the alphabet registers, the controller and the output valid
// a stall on text holds the current character; the next integer is taken once the
// final character is in the output register; a bad alphabet gives no characters
module signed_integer_to_radix_text_core
	import sitrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	sitrt_value_if.sink          number,
	sitrt_char_if.source         text
);

	// command and status between the controller and the datapath
	cmd_t         cmd;
	conv_status_t conv_st;
	chk_status_t  chk_st;

	// symbol lookup between the conversion cells and the alphabet
	logic [CNT_W-1:0]   radix;
	logic [SYM_W-1:0]   sym_data;
	logic [DIGIT_W-1:0] emit_idx;

	sitrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (number.ready),
		.conv_st  (conv_st),
		.chk_st   (chk_st),
		.cmd      (cmd)
	);

	// alphabet registers and the validity check (no duplicates, printable,
	// no sign characters, between two and the maximum number of symbols)
	sitrt_alpha u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.emit_idx  (emit_idx),
		.radix     (radix),
		.sym_data  (sym_data),
		.chk_st    (chk_st)
	);

	// magnitude shifted in msb first, digits kept least significant first
	sitrt_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (number.value),
		.radix      (radix),
		.sym_data   (sym_data),
		.emit_idx   (emit_idx),
		.conv_st    (conv_st),
		.out_valid  (text.valid),
		.out_ready  (text.ready),
		.out_symbol (text.symbol),
		.out_last   (text.last)
	);

endmodule

// ===== rtl/sitrt_ctrl.sv =====
// Controller state machine: sequences conversion, alphabet check and emission.
// Depends on sitrt_pkg.
module sitrt_ctrl
	import sitrt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  conv_status_t conv_st,
	input  chk_status_t  chk_st,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				if (conv_st.conv_done && chk_st.chk_done) begin
					if (!chk_st.chk_ok) begin
						state_d = ST_IDLE;
					end else if (conv_st.neg) begin
						state_d = ST_SIGN;
					end else begin
						state_d = ST_DIGITS;
					end
				end
			end
			ST_SIGN: begin
				if (conv_st.out_free) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (conv_st.out_free && conv_st.digit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd.start      = (state_q == ST_IDLE) && in_valid;
		cmd.emit_sign  = (state_q == ST_SIGN) && conv_st.out_free;
		cmd.emit_digit = (state_q == ST_DIGITS) && conv_st.out_free;
	end

endmodule

// ===== rtl/sitrt_alpha.sv =====
// Alphabet registers, symbol read port and serial alphabet validity check.
// Depends on sitrt_pkg.
module sitrt_alpha
	import sitrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  cmd_t                 cmd,
	input  logic [DIGIT_W-1:0]   emit_idx,
	output logic [CNT_W-1:0]     radix,
	output logic [SYM_W-1:0]     sym_data,
	output chk_status_t          chk_st
);

	logic [CNT_W-1:0]      count_q;
	logic [WORD_W-1:0]     words_q [WORD_COUNT];
	logic [CHAR_SPACE-1:0] seen_q;
	logic [CNT_W-1:0]      chk_idx_q;
	logic                  chk_busy_q;
	logic                  chk_ok_q;

	logic [CNT_W-1:0]  rd_idx;
	logic [WSEL_W-1:0] word_sel;
	logic              bad_char;
	logic              dup_char;
	logic              chk_last;
	logic              count_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int w = 0; w < WORD_COUNT; w++) begin
				words_q[w] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_SYMBOL_COUNT: begin
					count_q <= cfg_data[CNT_W-1:0];
				end
				[REG_SYMBOLS_WORD0:REG_SYMBOLS_WORD5]: begin
					words_q[cfg_index - REG_SYMBOLS_WORD0] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// one symbol read port, shared by the check and the emission
	always_comb begin
		rd_idx   = chk_busy_q ? chk_idx_q : emit_idx;
		word_sel = rd_idx[CNT_W-1:3];
		sym_data = '0;
		if (word_sel < WSEL_W'(WORD_COUNT)) begin
			sym_data = words_q[word_sel][{rd_idx[2:0], 3'b000} +: SYM_W];
		end
	end

	assign bad_char = (sym_data == CHAR_PLUS) || (sym_data == CHAR_MINUS)
		|| (sym_data < CHAR_LOW) || (sym_data > CHAR_HIGH);
	assign dup_char = seen_q[sym_data];
	assign chk_last = (chk_idx_q == count_q - CNT_W'(1));
	assign count_ok = (count_q >= CNT_W'(2)) && (count_q <= CNT_W'(MAX_SYMBOLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_busy_q <= 1'b0;
			chk_ok_q   <= 1'b0;
			chk_idx_q  <= '0;
		end else if (cmd.start) begin
			chk_busy_q <= count_ok;
			chk_ok_q   <= count_ok;
			chk_idx_q  <= '0;
		end else if (chk_busy_q) begin
			if (bad_char || dup_char) begin
				chk_ok_q   <= 1'b0;
				chk_busy_q <= 1'b0;
			end else if (chk_last) begin
				chk_busy_q <= 1'b0;
			end
			chk_idx_q <= chk_idx_q + CNT_W'(1);
		end
	end

	// characters already seen in this pass
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			seen_q <= '0;
		end else if (chk_busy_q) begin
			seen_q[sym_data] <= 1'b1;
		end
	end

	assign radix           = count_q;
	assign chk_st.chk_done = !chk_busy_q;
	assign chk_st.chk_ok   = chk_ok_q;

endmodule

// ===== rtl/sitrt_conv.sv =====
// Bit-serial binary to radix conversion over a row of digit cells, plus the
// output register. Depends on sitrt_pkg.
module sitrt_conv
	import sitrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [VALUE_W-1:0] value,
	input  logic [CNT_W-1:0]   radix,
	input  logic [SYM_W-1:0]   sym_data,
	output logic [DIGIT_W-1:0] emit_idx,
	output conv_status_t       conv_st,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SYM_W-1:0]   out_symbol,
	output logic               out_last
);

	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [DIGIT_W-1:0]   digit_q [DIGIT_DEPTH];
	logic [LEN_W-1:0]     len_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 conv_busy_q;
	logic                 out_valid_q;
	logic [SYM_W-1:0]     symbol_q;
	logic                 last_q;

	logic [DIGIT_W:0]     dbl    [DIGIT_DEPTH];
	logic [DIGIT_W:0]     diff   [DIGIT_DEPTH];
	logic [DIGIT_DEPTH-1:0] gen;
	logic [DIGIT_DEPTH-1:0] gen_or_prop;
	logic [DIGIT_DEPTH:0] csum;
	logic [DIGIT_DEPTH:0] carry;
	logic [DIGIT_W:0]     radix_x;
	logic [LEN_W-1:0]     ptr;
	logic                 out_free;

	// each cell doubles its digit and adds the carry from below; the carries
	// form a generate/propagate chain resolved by one adder
	always_comb begin
		radix_x = {1'b0, radix};
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			dbl[i]         = {digit_q[i], 1'b0};
			gen[i]         = (dbl[i] >= radix_x);
			gen_or_prop[i] = gen[i] || (dbl[i] == radix_x - (DIGIT_W+1)'(1));
		end
		csum  = {1'b0, gen_or_prop} + {1'b0, gen} + {{DIGIT_DEPTH{1'b0}}, mag_q[VALUE_W-1]};
		carry = csum ^ {1'b0, gen_or_prop} ^ {1'b0, gen};
		for (int i = 0; i < DIGIT_DEPTH; i++) begin
			diff[i] = {digit_q[i], carry[i]} - (carry[i+1] ? radix_x : '0);
		end
	end

	// read pointer is the most significant digit still to go
	assign ptr      = (len_q == '0) ? '0 : len_q - LEN_W'(1);
	assign emit_idx = digit_q[ptr[PTR_W-1:0]];
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_busy_q <= 1'b0;
			bit_cnt_q   <= '0;
			len_q       <= '0;
		end else if (cmd.start) begin
			conv_busy_q <= 1'b1;
			bit_cnt_q   <= '0;
			len_q       <= '0;
		end else if (conv_busy_q) begin
			len_q     <= len_q + {{(LEN_W-1){1'b0}}, carry[len_q]};
			bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			if (bit_cnt_q == '1) begin
				conv_busy_q <= 1'b0;
			end
		end else if (cmd.emit_digit) begin
			len_q <= ptr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
			for (int i = 0; i < DIGIT_DEPTH; i++) begin
				digit_q[i] <= '0;
			end
		end else if (conv_busy_q) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			for (int i = 0; i < DIGIT_DEPTH; i++) begin
				digit_q[i] <= diff[i][DIGIT_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			symbol_q <= CHAR_MINUS;
			last_q   <= 1'b0;
		end else if (cmd.emit_digit) begin
			symbol_q <= sym_data;
			last_q   <= (ptr == '0);
		end
	end

	assign conv_st.conv_done  = !conv_busy_q;
	assign conv_st.neg        = neg_q;
	assign conv_st.out_free   = out_free;
	assign conv_st.digit_last = (ptr == '0);

	assign out_valid  = out_valid_q;
	assign out_symbol = symbol_q;
	assign out_last   = last_q;

endmodule
